// ===== rtl/gic_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gic_pkg
// shared widths, register indexes, button bit positions and the arctangent table
// ----------------------------------------------------------------------------
package gic_pkg;

    localparam int NUM_BUTTONS = 10;
    localparam int CORDIC_MAX  = 24;

    // serial divider: numerator, divisor and quotient widths
    localparam int DIV_NW = 40;
    localparam int DIV_DW = 25;
    localparam int DIV_QW = 17;

    // serial square root of r2 << 16: 32 bit operand, 24 bit root
    localparam int SQ_IW = 32;
    localparam int SQ_RW = 24;

    localparam int CNT_W = 5;

    localparam logic [7:0] CFG_LEFT_INNER  = 8'd0;
    localparam logic [7:0] CFG_RIGHT_INNER = 8'd1;
    localparam logic [7:0] CFG_OUTER       = 8'd2;
    localparam logic [7:0] CFG_TRIG_DZ     = 8'd3;

    localparam logic [15:0] RESET_LEFT_INNER  = 16'd7849;
    localparam logic [15:0] RESET_RIGHT_INNER = 16'd8689;
    localparam logic [15:0] RESET_OUTER       = 16'd32000;
    localparam logic [7:0]  RESET_TRIG_DZ     = 8'd30;

    localparam logic [15:0] Q15_ONE = 16'd32768;

    // position in the raw button word of A B X Y LS RS start back LC RC
    localparam logic [3:0] BTN_POS [NUM_BUTTONS] = '{
        4'd12, 4'd13, 4'd14, 4'd15, 4'd8, 4'd9, 4'd4, 4'd5, 4'd6, 4'd7
    };

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    function automatic logic [16:0] abs17(input logic signed [15:0] a);
        logic [16:0] e;
        e = {a[15], a};
        return a[15] ? (17'd0 - e) : e;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gic_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gic_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module gic_div import gic_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [DIV_NW-1:0] num,
    input  wire logic [DIV_DW-1:0] den,
    output logic                   busy,
    output logic                   done,
    output logic [DIV_QW-1:0]      quo
);

    logic [DIV_DW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_QW-1:0] low_reg;
    logic [DIV_QW-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    always_comb begin
        trial    = {rem_reg, low_reg[DIV_QW-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = !diff[DIV_DW];
        rem_next = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
                low_reg  <= num[DIV_QW-1:0];
                den_reg  <= den;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                low_reg <= {low_reg[DIV_QW-2:0], 1'b0};
                quo_reg <= {quo_reg[DIV_QW-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_QW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/gic_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gic_sqrt
// integer square root of r2 * 65536, one root bit per cycle
// ----------------------------------------------------------------------------
module gic_sqrt import gic_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [SQ_IW-1:0] r2,
    output logic                  done,
    output logic [SQ_RW-1:0]      root
);

    logic [SQ_IW-1:0] v_reg;
    logic [SQ_RW:0]   rem_reg;
    logic [SQ_RW-1:0] root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SQ_RW+2:0] t;
    logic [SQ_RW+2:0] trial;
    logic [SQ_RW+2:0] diff;
    logic             ge;

    always_comb begin
        t     = {rem_reg, v_reg[SQ_IW-1:SQ_IW-2]};
        trial = {1'b0, root_reg, 2'b01};
        diff  = t - trial;
        ge    = (t >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                v_reg    <= r2;
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                // the low 16 operand bits are zero, shifted in behind r2
                v_reg    <= {v_reg[SQ_IW-3:0], 2'b00};
                rem_reg  <= ge ? diff[SQ_RW:0] : t[SQ_RW:0];
                root_reg <= {root_reg[SQ_RW-2:0], ge};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_RW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule
`default_nettype wire

// ===== rtl/gic_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gic_cordic
// vectoring cordic, one micro-rotation per cycle, angle in 2^-16 turn
// ----------------------------------------------------------------------------
module gic_cordic import gic_pkg::*; #(
    parameter int ITER = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [15:0] x_in,
    input  wire logic signed [15:0] y_in,
    output logic                    busy,
    output logic [15:0]             angle
);

    logic signed [26:0] x_reg, y_reg;
    logic [31:0]        z_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic signed [26:0] xs, ys, dx, dy;
    logic [31:0]        zr;

    always_comb begin
        xs = 27'(x_in) <<< 8;
        ys = 27'(y_in) <<< 8;
        dx = y_reg >>> cnt_reg;
        dy = x_reg >>> cnt_reg;
        zr = z_reg + 32'h0000_8000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                // left half plane: turn by half a turn first
                if (x_in[15]) begin
                    x_reg <= -xs;
                    y_reg <= -ys;
                    z_reg <= 32'h8000_0000;
                end else begin
                    x_reg <= xs;
                    y_reg <= ys;
                    z_reg <= '0;
                end
            end else if (busy_reg) begin
                if (y_reg > 0) begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_turn(cnt_reg);
                end else begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_turn(cnt_reg);
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ITER - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign busy  = busy_reg;
    assign angle = zr[31:16];

endmodule
`default_nettype wire

// ===== rtl/gamepad_input_conditioner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// button edges, trigger deadzone, radial stick deadzones and stick angles for one poll
// ----------------------------------------------------------------------------
// each accepted poll runs the trigger divisions, then per stick the squares, the square root
//   with the cordic angle beside it, the radial division and the two axis divisions
// the serial divider is used up to eight times per poll; polls are taken one at a time
// a disconnected poll is dropped and s_ready stays high; a finished result waits in the
//   output register while the next poll starts
// reset: synchronous active-low aresetn restores the deadzone defaults and clears the stored button levels
// ----------------------------------------------------------------------------
module gamepad_input_conditioner import gic_pkg::*; #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_connected,
    input  wire logic [15:0]        s_button_word,
    input  wire logic [7:0]         s_left_trigger_raw,
    input  wire logic [7:0]         s_right_trigger_raw,
    input  wire logic signed [15:0] s_left_axis_x,
    input  wire logic signed [15:0] s_left_axis_y,
    input  wire logic signed [15:0] s_right_axis_x,
    input  wire logic signed [15:0] s_right_axis_y,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [9:0]              m_buttons_down,
    output logic [9:0]              m_buttons_changed,
    output logic [15:0]             m_left_trigger_out,
    output logic [15:0]             m_right_trigger_out,
    output logic signed [15:0]      m_left_out_x,
    output logic signed [15:0]      m_left_out_y,
    output logic signed [15:0]      m_right_out_x,
    output logic signed [15:0]      m_right_out_y,
    output logic [15:0]             m_left_out_radius,
    output logic [15:0]             m_right_out_radius,
    output logic [15:0]             m_left_out_angle,
    output logic [15:0]             m_right_out_angle
);

    localparam int CORDIC_ITER = (ANGLE_BITS < CORDIC_MAX) ? ANGLE_BITS : CORDIC_MAX;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TRG, ST_TRG_WAIT, ST_X2, ST_Y2, ST_IN2, ST_OUT2, ST_SQRT,
        ST_SQRT_WAIT, ST_RAD, ST_RAD_WAIT, ST_MUL, ST_DIV, ST_DIV_WAIT, ST_ANG, ST_OUT
    } state_t;

    state_t state_reg;

    logic [15:0] l_inner_reg, r_inner_reg, outer_reg;
    logic [7:0]  tdz_reg;

    logic [9:0]         prev_reg, down_reg, changed_reg;
    logic [7:0]         ltrig_reg, rtrig_reg;
    logic signed [15:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic               tsel_reg, ssel_reg, asel_reg;
    logic [15:0]        ltres_reg, rtres_reg;
    logic [31:0]        r2_reg;
    logic               lt_in_reg, gt_out_reg;
    logic [SQ_RW-1:0]   r8_reg;
    logic [15:0]        rad_reg;
    logic [30:0]        prod_reg;
    logic [15:0]        res_x_reg [2];
    logic [15:0]        res_y_reg [2];
    logic [15:0]        res_rad_reg [2];
    logic [15:0]        res_ang_reg [2];
    logic               m_valid_reg;

    // selected operands
    logic signed [15:0] cur_x, cur_y, cur_a;
    logic [15:0]        cur_inner;
    logic [7:0]         cur_raw;
    logic [16:0]        mul_a, mul_b;
    logic [33:0]        prod;
    logic [9:0]         down_now;
    logic [DIV_DW-1:0]  den_rad;
    logic [SQ_RW-1:0]   r8_off;

    // shared units
    logic              div_start, div_busy, div_done;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_QW-1:0] div_quo;
    logic              sq_start, sq_done;
    logic [SQ_RW-1:0]  sq_root;
    logic              cd_busy;
    logic [15:0]       cd_angle;
    logic [16:0]       q_neg;
    logic [15:0]       axis_res;
    state_t            after_rad;

    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            down_now[i] = s_button_word[BTN_POS[i]];
        end
        cur_x     = ssel_reg ? rx_reg : lx_reg;
        cur_y     = ssel_reg ? ry_reg : ly_reg;
        cur_a     = asel_reg ? cur_y : cur_x;
        cur_inner = ssel_reg ? r_inner_reg : l_inner_reg;
        cur_raw   = tsel_reg ? rtrig_reg : ltrig_reg;
        den_rad   = DIV_DW'({outer_reg - cur_inner, 8'd0});
        r8_off    = r8_reg - {cur_inner, 8'd0};
        after_rad = (r2_reg == 32'd0) ? ST_ANG : ST_MUL;

        case (state_reg)
            ST_X2:   begin mul_a = abs17(cur_x);        mul_b = abs17(cur_x); end
            ST_Y2:   begin mul_a = abs17(cur_y);        mul_b = abs17(cur_y); end
            ST_IN2:  begin mul_a = {1'b0, cur_inner};   mul_b = {1'b0, cur_inner}; end
            ST_OUT2: begin mul_a = {1'b0, outer_reg};   mul_b = {1'b0, outer_reg}; end
            default: begin mul_a = abs17(cur_a);        mul_b = {1'b0, rad_reg}; end
        endcase
        prod = mul_a * mul_b;

        div_start = 1'b0;
        case (state_reg)
            ST_TRG: begin
                div_num   = DIV_NW'({cur_raw, 15'd127});
                div_den   = DIV_DW'(255);
                div_start = (cur_raw >= tdz_reg);
            end
            ST_RAD: begin
                // (r8 - inner*256) * 32768 + den / 2
                div_num   = DIV_NW'({r8_off, 15'd0}) + DIV_NW'({outer_reg - cur_inner, 7'd0});
                div_den   = den_rad;
                div_start = !lt_in_reg && !gt_out_reg && (outer_reg > cur_inner);
            end
            default: begin
                div_num   = DIV_NW'({prod_reg, 9'd0}) + DIV_NW'(r8_reg);
                div_den   = {r8_reg, 1'b0};
                div_start = (state_reg == ST_DIV);
            end
        endcase

        sq_start = (state_reg == ST_SQRT);

        // saturate the scaled axis by sign
        q_neg = (div_quo > 17'd32768) ? 17'd32768 : div_quo;
        if (cur_a[15]) begin
            axis_res = 16'(17'd0 - q_neg);
        end else begin
            axis_res = (div_quo > 17'd32767) ? 16'd32767 : div_quo[15:0];
        end
    end

    gic_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .busy   (div_busy),
        .done   (div_done),
        .quo    (div_quo)
    );

    gic_sqrt u_sqrt (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sq_start),
        .r2     (r2_reg),
        .done   (sq_done),
        .root   (sq_root)
    );

    gic_cordic #(.ITER(CORDIC_ITER)) u_cordic (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (sq_start),
        .x_in   (cur_x),
        .y_in   (cur_y),
        .busy   (cd_busy),
        .angle  (cd_angle)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            l_inner_reg <= RESET_LEFT_INNER;
            r_inner_reg <= RESET_RIGHT_INNER;
            outer_reg   <= RESET_OUTER;
            tdz_reg     <= RESET_TRIG_DZ;
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_LEFT_INNER:  l_inner_reg <= cfg_data;
                    CFG_RIGHT_INNER: r_inner_reg <= cfg_data;
                    CFG_OUTER:       outer_reg   <= cfg_data;
                    CFG_TRIG_DZ:     tdz_reg     <= cfg_data[7:0];
                    default: ;
                endcase
            end

            // in ST_OUT the output register is reloaded below instead
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_connected) begin
                        down_reg    <= down_now;
                        changed_reg <= down_now ^ prev_reg;
                        prev_reg    <= down_now;
                        ltrig_reg   <= s_left_trigger_raw;
                        rtrig_reg   <= s_right_trigger_raw;
                        lx_reg      <= s_left_axis_x;
                        ly_reg      <= s_left_axis_y;
                        rx_reg      <= s_right_axis_x;
                        ry_reg      <= s_right_axis_y;
                        tsel_reg    <= 1'b0;
                        state_reg   <= ST_TRG;
                    end
                end
                ST_TRG: begin
                    if (cur_raw < tdz_reg) begin
                        if (tsel_reg) begin
                            rtres_reg <= '0;
                            ssel_reg  <= 1'b0;
                            state_reg <= ST_X2;
                        end else begin
                            ltres_reg <= '0;
                            tsel_reg  <= 1'b1;
                        end
                    end else begin
                        state_reg <= ST_TRG_WAIT;
                    end
                end
                ST_TRG_WAIT: begin
                    if (div_done) begin
                        if (tsel_reg) begin
                            rtres_reg <= div_quo[15:0];
                            ssel_reg  <= 1'b0;
                            state_reg <= ST_X2;
                        end else begin
                            ltres_reg <= div_quo[15:0];
                            tsel_reg  <= 1'b1;
                            state_reg <= ST_TRG;
                        end
                    end
                end
                ST_X2: begin
                    r2_reg    <= prod[31:0];
                    state_reg <= ST_Y2;
                end
                ST_Y2: begin
                    r2_reg    <= r2_reg + prod[31:0];
                    state_reg <= ST_IN2;
                end
                ST_IN2: begin
                    lt_in_reg <= (r2_reg < prod[31:0]);
                    state_reg <= ST_OUT2;
                end
                ST_OUT2: begin
                    gt_out_reg <= (r2_reg > prod[31:0]);
                    state_reg  <= ST_SQRT;
                end
                ST_SQRT: begin
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT: begin
                    if (sq_done) begin
                        r8_reg    <= sq_root;
                        state_reg <= ST_RAD;
                    end
                end
                ST_RAD: begin
                    asel_reg <= 1'b0;
                    if (lt_in_reg) begin
                        rad_reg   <= '0;
                        state_reg <= after_rad;
                    end else if (div_start) begin
                        state_reg <= ST_RAD_WAIT;
                    end else begin
                        rad_reg   <= Q15_ONE;
                        state_reg <= after_rad;
                    end
                end
                ST_RAD_WAIT: begin
                    if (div_done) begin
                        rad_reg   <= (div_quo > 17'd32768) ? Q15_ONE : div_quo[15:0];
                        state_reg <= after_rad;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= prod[30:0];
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        if (asel_reg) begin
                            res_y_reg[ssel_reg] <= axis_res;
                            state_reg           <= ST_ANG;
                        end else begin
                            res_x_reg[ssel_reg] <= axis_res;
                            asel_reg            <= 1'b1;
                            state_reg           <= ST_MUL;
                        end
                    end
                end
                ST_ANG: begin
                    if (!cd_busy) begin
                        res_rad_reg[ssel_reg] <= rad_reg;
                        // stick at center: everything but the radius reads zero
                        if (r2_reg == 32'd0) begin
                            res_x_reg[ssel_reg]   <= '0;
                            res_y_reg[ssel_reg]   <= '0;
                            res_ang_reg[ssel_reg] <= '0;
                        end else begin
                            res_ang_reg[ssel_reg] <= cd_angle;
                        end
                        if (ssel_reg) begin
                            state_reg <= ST_OUT;
                        end else begin
                            ssel_reg  <= 1'b1;
                            state_reg <= ST_X2;
                        end
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg         <= 1'b1;
                        m_buttons_down      <= down_reg;
                        m_buttons_changed   <= changed_reg;
                        m_left_trigger_out  <= ltres_reg;
                        m_right_trigger_out <= rtres_reg;
                        m_left_out_x        <= res_x_reg[0];
                        m_left_out_y        <= res_y_reg[0];
                        m_right_out_x       <= res_x_reg[1];
                        m_right_out_y       <= res_y_reg[1];
                        m_left_out_radius   <= res_rad_reg[0];
                        m_right_out_radius  <= res_rad_reg[1];
                        m_left_out_angle    <= res_ang_reg[0];
                        m_right_out_angle   <= res_ang_reg[1];
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;

`ifndef SYNTHESIS
    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_drop_disconnected: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && !s_connected) |=> s_ready)
        else $error("disconnected request was not dropped");

    a_radius_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_out_radius <= Q15_ONE && m_right_out_radius <= Q15_ONE))
        else $error("radius above one");

    a_trigger_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_trigger_out <= Q15_ONE && m_right_trigger_out <= Q15_ONE))
        else $error("trigger above one");
`endif

endmodule
`default_nettype wire
